### rtl/core/ryuy_pkg.sv
`timescale 1ns / 1ps

package ryuy_pkg;

    localparam int PIX_W  = 16;
    localparam int CH_W   = 8;
    localparam int COEF_W = 16;
    localparam int PROD_W = COEF_W + CH_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC_W = 16;

    // Average masks for the per-channel RGB565 half-sum.
    localparam logic [PIX_W-1:0] AVG_MASK_HI = 16'hFBEF;
    localparam logic [PIX_W-1:0] AVG_MASK_LO = 16'h0821;

    // Coefficient magnitudes in unsigned 0.16 fixed point; signs are applied in the adders.
    localparam logic [COEF_W-1:0] Y_R_COEF  = 16'd19595;
    localparam logic [COEF_W-1:0] Y_G_COEF  = 16'd38469;
    localparam logic [COEF_W-1:0] Y_B_COEF  = 16'd7471;
    localparam logic [COEF_W-1:0] CB_R_COEF = 16'd11075;
    localparam logic [COEF_W-1:0] CB_G_COEF = 16'd21692;
    localparam logic [COEF_W-1:0] CR_G_COEF = 16'd27459;
    localparam logic [COEF_W-1:0] CR_B_COEF = 16'd5308;
    // The 0.5 coefficient is 32768, a left shift by this amount.
    localparam int HALF_SHIFT = 15;

    localparam logic signed [SUM_W-1:0] Y_OFFSET  = SUM_W'(16 << FRAC_W);
    localparam logic signed [SUM_W-1:0] CH_OFFSET = SUM_W'(128 << FRAC_W);

    localparam logic [CH_W-1:0] Y_MIN = 8'd16;
    localparam logic [CH_W-1:0] Y_MAX = 8'd235;
    localparam logic [CH_W-1:0] C_MIN = 8'd16;
    localparam logic [CH_W-1:0] C_MAX = 8'd240;

    localparam logic [31:0] BLACK_PAIR_WORD = 32'h0080_0080;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb8_t;

    // Stage 1 result: widened pixels, widened average, black-pair flag.
    typedef struct packed {
        rgb8_t px1;
        rgb8_t px2;
        rgb8_t avg;
        logic  black;
    } unpack_t;

    // Final sums in signed 10.16 fixed point, before the shift and clamp.
    typedef struct packed {
        logic signed [SUM_W-1:0] y1;
        logic signed [SUM_W-1:0] y2;
        logic signed [SUM_W-1:0] cb;
        logic signed [SUM_W-1:0] cr;
        logic                    black;
    } sums_t;

    function automatic rgb8_t widen565(input logic [PIX_W-1:0] p);
        rgb8_t c;
        c.r = {p[15:11], p[15:13]};
        c.g = {p[10:5],  p[10:9]};
        c.b = {p[4:0],   p[4:2]};
        return c;
    endfunction

endpackage

### rtl/core/ryuy_unpack.sv
`timescale 1ns / 1ps

module ryuy_unpack (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ryuy_pkg::PIX_W-1:0]   pixel_first,
    input  logic [ryuy_pkg::PIX_W-1:0]   pixel_second,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ryuy_pkg::unpack_t            out_data
);

    logic                  valid_reg;
    ryuy_pkg::unpack_t     data_reg;
    ryuy_pkg::unpack_t     data_next;
    logic [ryuy_pkg::PIX_W-1:0] avg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        avg = ((pixel_first >> 1) & ryuy_pkg::AVG_MASK_HI)
            + ((pixel_second >> 1) & ryuy_pkg::AVG_MASK_HI)
            + (pixel_first & pixel_second & ryuy_pkg::AVG_MASK_LO);
        data_next.px1   = ryuy_pkg::widen565(pixel_first);
        data_next.px2   = ryuy_pkg::widen565(pixel_second);
        data_next.avg   = ryuy_pkg::widen565(avg);
        data_next.black = ((pixel_first | pixel_second) == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/ryuy_matrix.sv
`timescale 1ns / 1ps

module ryuy_matrix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ryuy_pkg::unpack_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ryuy_pkg::sums_t    out_data
);

    localparam int PW = ryuy_pkg::PROD_W;
    localparam int SW = ryuy_pkg::SUM_W;

    // Product stage.
    logic          prod_valid_reg;
    logic          prod_ready;
    logic [PW-1:0] y1r_reg, y1g_reg, y1b_reg;
    logic [PW-1:0] y2r_reg, y2g_reg, y2b_reg;
    logic [PW-1:0] cbr_reg, cbg_reg, crg_reg, crb_reg;
    logic [ryuy_pkg::CH_W-1:0] avg_r_reg, avg_b_reg;
    logic          prod_black_reg;

    // Sum stage.
    logic              sum_valid_reg;
    logic              sum_ready;
    ryuy_pkg::sums_t   sum_reg;
    ryuy_pkg::sums_t   sum_next;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (sum_ready) begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            y1r_reg <= PW'(ryuy_pkg::Y_R_COEF) * PW'(in_data.px1.r);
            y1g_reg <= PW'(ryuy_pkg::Y_G_COEF) * PW'(in_data.px1.g);
            y1b_reg <= PW'(ryuy_pkg::Y_B_COEF) * PW'(in_data.px1.b);
            y2r_reg <= PW'(ryuy_pkg::Y_R_COEF) * PW'(in_data.px2.r);
            y2g_reg <= PW'(ryuy_pkg::Y_G_COEF) * PW'(in_data.px2.g);
            y2b_reg <= PW'(ryuy_pkg::Y_B_COEF) * PW'(in_data.px2.b);
            cbr_reg <= PW'(ryuy_pkg::CB_R_COEF) * PW'(in_data.avg.r);
            cbg_reg <= PW'(ryuy_pkg::CB_G_COEF) * PW'(in_data.avg.g);
            crg_reg <= PW'(ryuy_pkg::CR_G_COEF) * PW'(in_data.avg.g);
            crb_reg <= PW'(ryuy_pkg::CR_B_COEF) * PW'(in_data.avg.b);
            avg_r_reg      <= in_data.avg.r;
            avg_b_reg      <= in_data.avg.b;
            prod_black_reg <= in_data.black;
        end
    end

    always_comb begin
        sum_next.y1 = ryuy_pkg::Y_OFFSET + $signed(SW'(y1r_reg)) + $signed(SW'(y1g_reg))
                    + $signed(SW'(y1b_reg));
        sum_next.y2 = ryuy_pkg::Y_OFFSET + $signed(SW'(y2r_reg)) + $signed(SW'(y2g_reg))
                    + $signed(SW'(y2b_reg));
        sum_next.cb = ryuy_pkg::CH_OFFSET
                    + $signed(SW'(avg_b_reg) << ryuy_pkg::HALF_SHIFT)
                    - $signed(SW'(cbr_reg)) - $signed(SW'(cbg_reg));
        sum_next.cr = ryuy_pkg::CH_OFFSET
                    + $signed(SW'(avg_r_reg) << ryuy_pkg::HALF_SHIFT)
                    - $signed(SW'(crg_reg)) - $signed(SW'(crb_reg));
        sum_next.black = prod_black_reg;
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && prod_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_data  = sum_reg;

endmodule

### rtl/core/ryuy_clamp.sv
`timescale 1ns / 1ps

module ryuy_clamp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ryuy_pkg::sums_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_word
);

    localparam int CW = ryuy_pkg::CH_W;
    localparam int FW = ryuy_pkg::FRAC_W;
    localparam int SW = ryuy_pkg::SUM_W;

    logic          valid_reg;
    logic [31:0]   word_reg;
    logic [31:0]   word_next;
    logic [CW-1:0] y1, y2, cb, cr;

    // Drops the fraction, treats a negative sum as zero, and clamps to [lo, hi].
    function automatic logic [CW-1:0] shift_clamp(input logic signed [SW-1:0] s,
                                                   input logic [CW-1:0] lo,
                                                   input logic [CW-1:0] hi);
        logic [SW-FW-1:0] v;
        v = s[SW-1] ? '0 : s[SW-1:FW];
        if (v < (SW-FW)'(lo)) begin
            return lo;
        end else if (v > (SW-FW)'(hi)) begin
            return hi;
        end
        return v[CW-1:0];
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        y1 = shift_clamp(in_data.y1, ryuy_pkg::Y_MIN, ryuy_pkg::Y_MAX);
        y2 = shift_clamp(in_data.y2, ryuy_pkg::Y_MIN, ryuy_pkg::Y_MAX);
        cb = shift_clamp(in_data.cb, ryuy_pkg::C_MIN, ryuy_pkg::C_MAX);
        cr = shift_clamp(in_data.cr, ryuy_pkg::C_MIN, ryuy_pkg::C_MAX);
        // A pair of black pixels maps to true zero luma rather than studio black.
        word_next = in_data.black ? ryuy_pkg::BLACK_PAIR_WORD : {y1, cb, y2, cr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### rtl/core/rgb565_pair_to_yuy2_core.sv
`timescale 1ns / 1ps

// RGB565 pixel pair to YUY2 converter (BT.601 coefficients, clamped to studio range).
// Input stream: one transfer carries two horizontally adjacent RGB565 pixels;
// the output stream returns one packed YUY2 word per input transfer, in order.
// Luma is computed per pixel; chroma comes from the channel average of the pair.
// A pair of all-zero pixels yields 0x00800080.
// Each result passes through four registered stages (unpack/average, constant
// multiplies, adder trees, shift/clamp/pack) before it appears on m_tdata.
// Throughput: one pair per clock while m_tready is high; every stage has its own
// valid bit and takes a new item whenever it is empty or its content moves on
// in the same cycle. When the receiver stalls, results stay in their stages and
// fill bubbles; s_tready falls only once all four stages hold data. Nothing is
// lost or repeated. Reset (aresetn low, synchronous) empties all stages; the
// block keeps no other state.
module rgb565_pair_to_yuy2_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_first [15:0], pixel_second [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // yuy2_word [31:0]
);

    logic              unp_valid, unp_ready;
    ryuy_pkg::unpack_t unp_data;
    logic              mat_valid, mat_ready;
    ryuy_pkg::sums_t   mat_data;

    ryuy_unpack u_unpack (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pixel_first  (s_tdata[15:0]),
        .pixel_second (s_tdata[31:16]),
        .out_valid    (unp_valid),
        .out_ready    (unp_ready),
        .out_data     (unp_data)
    );

    ryuy_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (unp_valid),
        .in_ready  (unp_ready),
        .in_data   (unp_data),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_data  (mat_data)
    );

    ryuy_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_data   (mat_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

    // A ready receiver must keep the whole pipeline open to new pairs.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tready |-> s_tready)
        else $error("input stalled while the output is ready");

    // Luma bytes stay within studio range unless the black-pair word is shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata != ryuy_pkg::BLACK_PAIR_WORD) |->
        (m_tdata[31:24] >= ryuy_pkg::Y_MIN && m_tdata[31:24] <= ryuy_pkg::Y_MAX &&
         m_tdata[15:8]  >= ryuy_pkg::Y_MIN && m_tdata[15:8]  <= ryuy_pkg::Y_MAX))
        else $error("luma out of range");

    // Chroma bytes always stay within 16..240, the black-pair word included.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
        (m_tdata[23:16] >= ryuy_pkg::C_MIN && m_tdata[23:16] <= ryuy_pkg::C_MAX &&
         m_tdata[7:0]   >= ryuy_pkg::C_MIN && m_tdata[7:0]   <= ryuy_pkg::C_MAX))
        else $error("chroma out of range");

    // An empty pipeline cannot present a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tvalid && !unp_valid && !mat_valid && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared from an empty pipeline");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [15:0] px_first;
        logic [15:0] px_second;
        logic [31:0] word;
    } yuy2_expect_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    yuy2_expect_t pending_words[$];
    int unsigned  mismatches = 0;
    int unsigned  send_gap_pct = 0;
    int unsigned  recv_stall_pct = 0;

    rgb565_pair_to_yuy2_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Channels are widened by replicating their top bits into the low bits.
    function automatic void widen_pixel(input logic [15:0] p, output int r, output int g,
                                        output int b);
        r = int'({p[15:11], p[15:13]});
        g = int'({p[10:5], p[10:9]});
        b = int'({p[4:0], p[4:2]});
    endfunction

    function automatic logic [7:0] clamp_byte(input int v, input int lo, input int hi);
        if (v < lo)
            return 8'(lo);
        if (v > hi)
            return 8'(hi);
        return 8'(v);
    endfunction

    function automatic logic [7:0] luma_byte(input logic [15:0] p);
        int r, g, b, acc;
        widen_pixel(p, r, g, b);
        acc = 19595 * r + 38469 * g + 7471 * b + (16 << 16);
        return clamp_byte(acc >>> 16, 16, 235);
    endfunction

    function automatic logic [31:0] yuy2_of_pair(input logic [15:0] p1, input logic [15:0] p2);
        logic [15:0] avg;
        int          r, g, b, cb_acc, cr_acc;
        logic [7:0]  cb, cr;
        if ((p1 | p2) == 16'd0)
            return 32'h0080_0080;
        // Per-channel half-sum, rounding each channel down.
        avg = ((p1 >> 1) & 16'hFBEF) + ((p2 >> 1) & 16'hFBEF) + (p1 & p2 & 16'h0821);
        widen_pixel(avg, r, g, b);
        cb_acc = -11075 * r - 21692 * g + 32768 * b + (128 << 16);
        cr_acc = 32768 * r - 27459 * g - 5308 * b + (128 << 16);
        if (cb_acc < 0)
            cb_acc = 0;
        if (cr_acc < 0)
            cr_acc = 0;
        cb = clamp_byte(cb_acc >>> 16, 16, 240);
        cr = clamp_byte(cr_acc >>> 16, 16, 240);
        return {luma_byte(p1), cb, luma_byte(p2), cr};
    endfunction

    task automatic send_pair(input logic [15:0] p1, input logic [15:0] p2);
        yuy2_expect_t e;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p2, p1};
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        e.px_first  = p1;
        e.px_second = p2;
        e.word      = yuy2_of_pair(p1, p2);
        pending_words.push_back(e);
    endtask

    // Receiver: random stalls plus the in-order compare of every output transfer.
    always @(posedge aclk) begin
        yuy2_expect_t e;
        if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t unexpected transfer: expected none, actual %h", $time, m_tdata);
            end else begin
                e = pending_words.pop_front();
                if (m_tdata !== e.word) begin
                    mismatches++;
                    $display("%0t pair %h/%h yuy2_word: expected %h, actual %h",
                             $time, e.px_first, e.px_second, e.word, m_tdata);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {$urandom_range(1) ? 5'h1F : 5'h00, $urandom_range(1) ? 6'h3F : 6'h00,
                       $urandom_range(1) ? 5'h1F : 5'h00};
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_black_pair();
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h0001, 16'h0000);
        send_pair(16'h0000, 16'h0020);
        send_pair(16'h0000, 16'h8000);
    endtask

    task automatic test_primaries_and_clamps();
        send_pair(16'hFFFF, 16'hFFFF);   // luma clamps high
        send_pair(16'hF800, 16'hF800);   // Cr clamps high
        send_pair(16'h07E0, 16'h07E0);
        send_pair(16'h001F, 16'h001F);   // Cb clamps high
        send_pair(16'hFFE0, 16'hFFE0);   // Cb clamps low
        send_pair(16'h07FF, 16'h07FF);   // Cr clamps low
        send_pair(16'hF81F, 16'h0000);
        send_pair(16'hFFFF, 16'h0000);
        send_pair(16'h0000, 16'hFFFF);
    endtask

    task automatic test_average_rounding();
        send_pair(16'h0821, 16'h0000);
        send_pair(16'h0821, 16'h0821);
        send_pair(16'hF7DE, 16'h0821);
        send_pair(16'h0800, 16'h0800);
        send_pair(16'h8410, 16'h7BEF);
        send_pair(16'h1234, 16'hABCD);
    endtask

    task automatic test_random_pairs(input int count, input int gap_pct, input int stall_pct);
        logic [15:0] p1, p2;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            p1 = random_pixel();
            case ($urandom_range(19))
                0: p2 = p1;
                1: begin
                    p1 = 16'h0000;
                    p2 = 16'h0000;
                end
                default: p2 = random_pixel();
            endcase
            send_pair(p1, p2);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_black_pair();
        test_primaries_and_clamps();
        test_average_rounding();
        test_random_pairs(450, 0, 0);
        test_random_pairs(450, 50, 0);
        test_random_pairs(450, 0, 50);
        test_random_pairs(450, 30, 30);
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/ryuy_pkg.sv
rtl/core/ryuy_unpack.sv
rtl/core/ryuy_matrix.sv
rtl/core/ryuy_clamp.sv
rtl/core/rgb565_pair_to_yuy2_core.sv
tb/sv/tb.sv
